@@ design/ucf_pkg.sv @@
`default_nettype none

package ucf_pkg;

    localparam int unsigned CapWidth   = 16;
    localparam int unsigned CountWidth = 16;
    localparam logic [CapWidth-1:0] CAP_RESET = 16'hFFFF;

    localparam logic [7:0] LEAD_D0 = 8'hD0;
    localparam logic [7:0] LEAD_D1 = 8'hD1;

    localparam logic [10:0] CP_YO_UPPER      = 11'h401;
    localparam logic [10:0] CP_YO_LOWER      = 11'h451;
    localparam logic [10:0] CP_IE_LOWER      = 11'h435;
    localparam logic [10:0] CP_SHORT_I_UPPER = 11'h419;
    localparam logic [10:0] CP_SHORT_I_LOWER = 11'h439;
    localparam logic [10:0] CP_I_LOWER       = 11'h438;
    localparam logic [10:0] CP_UPPER_FIRST   = 11'h410;
    localparam logic [10:0] CP_UPPER_LAST    = 11'h42F;
    localparam logic [10:0] CP_LOWER_FIRST   = 11'h430;
    localparam logic [10:0] CP_LOWER_LAST    = 11'h44F;
    localparam logic [10:0] CP_CASE_OFFSET   = 11'h020;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_OVERFLOW    = 2'd2
    } status_t;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    typedef struct packed {
        logic                  kind;
        logic [7:0]            out_byte;
        logic [1:0]            status;
        logic [CountWidth-1:0] written_count;
        logic                  end_of_run;
    } result_t;

    typedef struct packed {
        logic                  lead_pending;
        logic                  lead_is_d1;
        logic [CountWidth-1:0] bytes_written;
        status_t               error_latched;
    } fold_state_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] lead;
        logic [7:0] trail;
    } fold_t;

    // Folds the two-byte sequence whose lead is D0 (d1 low) or D1 (d1 high).
    function automatic fold_t ucf_fold(input logic d1, input logic [5:0] low);
        logic [10:0] cp;
        logic [10:0] f;
        fold_t       r;
        cp = {4'b1000, d1, low};
        f  = cp;
        r.ok = 1'b1;
        if (cp == CP_YO_UPPER || cp == CP_YO_LOWER) begin
            f = CP_IE_LOWER;
        end else if (cp == CP_SHORT_I_UPPER || cp == CP_SHORT_I_LOWER) begin
            f = CP_I_LOWER;
        end else if (cp >= CP_UPPER_FIRST && cp <= CP_UPPER_LAST) begin
            f = cp + CP_CASE_OFFSET;
        end else if (cp >= CP_LOWER_FIRST && cp <= CP_LOWER_LAST) begin
            f = cp;
        end else begin
            r.ok = 1'b0;
        end
        r.lead  = {3'b110, f[10:6]};
        r.trail = {2'b10, f[5:0]};
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/ucf_ifs.sv @@
`default_nettype none

interface ucf_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface ucf_fold_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [15:0] written_count;
    logic        end_of_run;

    modport source (output valid, output kind, output out_byte, output status,
                    output written_count, output end_of_run, input ready);
    modport sink (input valid, input kind, input out_byte, input status,
                  input written_count, input end_of_run, output ready);
endinterface

interface ucf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] byte_limit;

    modport source (output valid, output byte_limit, input ready);
    modport sink (input valid, input byte_limit, output ready);
endinterface

`default_nettype wire

@@ design/ucf_step.sv @@
`default_nettype none

module ucf_step
    import ucf_pkg::*;
(
    input  fold_state_t         cur,
    input  logic [CapWidth-1:0] capacity,
    input  logic [7:0]          in_byte,
    input  logic                is_last,
    output fold_state_t         nxt,
    output result_t [2:0]       results,
    output logic [1:0]          result_cnt
);

    fold_t             fold;
    logic [CapWidth:0] room_two;

    assign fold     = ucf_fold(cur.lead_is_d1, in_byte[5:0]);
    assign room_two = {1'b0, cur.bytes_written} + (CapWidth+1)'(2);

    always_comb
    begin
        nxt        = cur;
        results    = '0;
        result_cnt = 2'd0;

        if (cur.error_latched == ST_OK) begin
            if (cur.lead_pending) begin
                nxt.lead_pending = 1'b0;
                if (in_byte[7:6] != 2'b10 || !fold.ok) begin
                    nxt.error_latched = ST_UNSUPPORTED;
                end else if (room_two > {1'b0, capacity}) begin
                    nxt.error_latched = ST_OVERFLOW;
                end else begin
                    results[0].kind     = KIND_BYTE;
                    results[0].out_byte = fold.lead;
                    results[1].kind     = KIND_BYTE;
                    results[1].out_byte = fold.trail;
                    result_cnt          = 2'd2;
                    nxt.bytes_written   = cur.bytes_written + CountWidth'(2);
                end
            end else if (!in_byte[7]) begin
                if (cur.bytes_written >= capacity) begin
                    nxt.error_latched = ST_OVERFLOW;
                end else begin
                    results[0].kind = KIND_BYTE;
                    if (in_byte inside {[8'h41:8'h5A]}) begin
                        results[0].out_byte = in_byte + 8'h20;
                    end else begin
                        results[0].out_byte = in_byte;
                    end
                    result_cnt        = 2'd1;
                    nxt.bytes_written = cur.bytes_written + CountWidth'(1);
                end
            end else if ((in_byte == LEAD_D0 || in_byte == LEAD_D1) && !is_last) begin
                nxt.lead_pending = 1'b1;
                nxt.lead_is_d1   = (in_byte == LEAD_D1);
            end else begin
                nxt.error_latched = ST_UNSUPPORTED;
            end
        end

        if (is_last) begin
            results[result_cnt].kind          = KIND_END;
            results[result_cnt].status        = nxt.error_latched;
            results[result_cnt].written_count = nxt.bytes_written;
            result_cnt                        = result_cnt + 2'd1;
            nxt                               = '0;
        end

        if (result_cnt != 2'd0) begin
            results[result_cnt - 2'd1].end_of_run = 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ design/utf8_cyrillic_case_folder_core.sv @@
// Channel   Direction  Beat contents
// text      in         in_byte, is_last
// folded    out        kind, out_byte, status, written_count, end_of_run
// cfg       in         byte_limit
//
// A byte is folded in the cycle it is accepted; its results (up to three beats)
// sit in a group register and leave at one beat per cycle.
// A new byte is accepted in the cycle the last beat of the previous group
// leaves, so the rate is one byte per cycle while each byte yields at most one
// beat; a Cyrillic pair or an end result holds the input until its extra beats
// have left. A stall on folded holds the input the same way.
// Reset clears the fold state, empties the group and sets the capacity to 65535.
`default_nettype none

module utf8_cyrillic_case_folder_core
    import ucf_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    ucf_text_if.sink      text,
    ucf_fold_if.source    folded,
    ucf_cfg_if.sink       cfg
);

    fold_state_t         state_reg;
    fold_state_t         state_next;
    logic [CapWidth-1:0] capacity_reg;
    result_t [2:0]       grp_reg;
    result_t [2:0]       grp_next;
    logic [1:0]          cnt_reg;
    logic [1:0]          idx_reg;
    logic [1:0]          step_cnt;
    logic                pending;
    logic                pop;
    logic                last_beat;
    logic                take;
    result_t             head;

    ucf_step u_step (
        .cur        (state_reg),
        .capacity   (capacity_reg),
        .in_byte    (text.in_byte),
        .is_last    (text.is_last),
        .nxt        (state_next),
        .results    (grp_next),
        .result_cnt (step_cnt)
    );

    assign pending   = (cnt_reg != idx_reg);
    assign pop       = folded.valid && folded.ready;
    assign last_beat = (idx_reg + 2'd1 == cnt_reg);
    assign text.ready = !pending || (pop && last_beat);
    assign take      = text.valid && text.ready;
    assign cfg.ready = 1'b1;

    assign head                 = grp_reg[idx_reg];
    assign folded.valid         = pending;
    assign folded.kind          = head.kind;
    assign folded.out_byte      = head.out_byte;
    assign folded.status        = head.status;
    assign folded.written_count = head.written_count;
    assign folded.end_of_run    = head.end_of_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= '0;
            capacity_reg <= CAP_RESET;
            cnt_reg      <= 2'd0;
            idx_reg      <= 2'd0;
        end else begin
            if (cfg.valid) begin
                capacity_reg <= cfg.byte_limit;
            end
            if (take) begin
                state_reg <= state_next;
                cnt_reg   <= step_cnt;
                idx_reg   <= 2'd0;
            end else if (pop) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            grp_reg <= grp_next;
        end
    end

    // The end result is always the final beat of its group.
    assert property (@(posedge clk) disable iff (!rst_n)
        folded.valid && folded.kind |-> folded.end_of_run)
        else $error("end result not marked as the final beat");

    // A final byte always leaves an end result behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && text.is_last |=> folded.valid && (cnt_reg != 2'd0))
        else $error("final byte produced no result");

    // Inside a group, a beat that is not the final one is followed by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && !folded.end_of_run |=> folded.valid)
        else $error("group ended without an end-of-run beat");

    // A latched error never coexists with a waiting lead byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.error_latched != ST_OK |-> !state_reg.lead_pending)
        else $error("lead byte pending after an error");

endmodule

`default_nettype wire

@@ tb/sv/utf8_cyrillic_case_folder_core_test.sv @@
`timescale 1ns / 1ps

module utf8_cyrillic_case_folder_core_test
    import ucf_pkg::*;
();

    localparam int QuietLimit  = 4000;
    localparam int DrainCycles = 8;
    localparam int HoldCycles  = 400;

    logic clk;
    logic rst_n;

    ucf_text_if text_ch ();
    ucf_fold_if fold_ch ();
    ucf_cfg_if  cfg_ch ();

    utf8_cyrillic_case_folder_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .folded (fold_ch),
        .cfg    (cfg_ch)
    );

    // Predicted fold state and capacity, kept alongside the block.
    fold_state_t   model_state;
    logic [15:0]   model_cap;
    result_t       expected_folds[$];
    logic [7:0]    text_bytes[$];

    int error_count  = 0;
    int bytes_sent   = 0;
    int beats_seen   = 0;
    int cap_writes   = 0;
    int ends_ok      = 0;
    int ends_unsup   = 0;
    int ends_ovf     = 0;
    int quiet_cycles = 0;
    int hold_request = 0;
    bit no_idle      = 1'b0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic result_t make_beat(input kind_t k, input logic [7:0] b,
                                          input status_t st, input logic [15:0] cnt);
        result_t r;
        r.kind          = k;
        r.out_byte      = b;
        r.status        = st;
        r.written_count = cnt;
        r.end_of_run    = 1'b0;
        return r;
    endfunction

    // Advances the predicted state by one text byte and queues the beats it causes.
    function automatic void fold_predict(input logic [7:0] b, input logic last);
        result_t     beats [3];
        int          n;
        int unsigned cp;
        int unsigned lower_cp;
        int unsigned count;
        bit          foldable;
        n     = 0;
        count = model_state.bytes_written;
        if (model_state.error_latched == ST_OK) begin
            if (model_state.lead_pending) begin
                model_state.lead_pending = 1'b0;
                cp = 32'h400 + (model_state.lead_is_d1 ? 32'h40 : 32'h0) + b[5:0];
                foldable = 1'b1;
                lower_cp = cp;
                if (cp == CP_YO_UPPER || cp == CP_YO_LOWER)
                    lower_cp = CP_IE_LOWER;
                else if (cp == CP_SHORT_I_UPPER || cp == CP_SHORT_I_LOWER)
                    lower_cp = CP_I_LOWER;
                else if (cp >= CP_UPPER_FIRST && cp <= CP_UPPER_LAST)
                    lower_cp = cp + CP_CASE_OFFSET;
                else if (!(cp >= CP_LOWER_FIRST && cp <= CP_LOWER_LAST))
                    foldable = 1'b0;
                if (b[7:6] != 2'b10 || !foldable) begin
                    model_state.error_latched = ST_UNSUPPORTED;
                end else if (count + 2 > model_cap) begin
                    model_state.error_latched = ST_OVERFLOW;
                end else begin
                    beats[n] = make_beat(KIND_BYTE, {3'b110, lower_cp[10:6]}, ST_OK, '0);
                    n++;
                    beats[n] = make_beat(KIND_BYTE, {2'b10, lower_cp[5:0]}, ST_OK, '0);
                    n++;
                    model_state.bytes_written = count + 2;
                end
            end else if (b < 8'h80) begin
                if (count >= model_cap) begin
                    model_state.error_latched = ST_OVERFLOW;
                end else begin
                    beats[n] = make_beat(KIND_BYTE,
                                         (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b,
                                         ST_OK, '0);
                    n++;
                    model_state.bytes_written = count + 1;
                end
            end else if ((b == LEAD_D0 || b == LEAD_D1) && !last) begin
                model_state.lead_pending = 1'b1;
                model_state.lead_is_d1   = (b == LEAD_D1);
            end else begin
                model_state.error_latched = ST_UNSUPPORTED;
            end
        end
        if (last) begin
            beats[n] = make_beat(KIND_END, 8'h00, model_state.error_latched,
                                 model_state.bytes_written);
            n++;
            model_state = '0;
        end
        if (n > 0)
            beats[n-1].end_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            expected_folds.push_back(beats[i]);
    endfunction

    // Offers one byte and returns at the falling edge after its acceptance.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_idle && $urandom_range(0, 99) < 23) begin
            text_ch.valid = 1'b0;
            @(negedge clk);
        end
        text_ch.valid   = 1'b1;
        text_ch.in_byte = b;
        text_ch.is_last = last;
        do
            @(posedge clk);
        while (!text_ch.ready);
        fold_predict(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_string();
        for (int i = 0; i < text_bytes.size(); i++)
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        text_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_folds.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic set_capacity(input logic [15:0] cap);
        wait_drained();
        cfg_ch.valid      = 1'b1;
        cfg_ch.byte_limit = cap;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        model_cap = cap;
        cap_writes++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic logic [10:0] random_letter(input bit any_code);
        int pick;
        pick = $urandom_range(0, 99);
        if (any_code && pick < 20)
            return 11'h400 + 11'($urandom_range(0, 127));
        if (pick < 35) begin
            case ($urandom_range(0, 3))
                0: return CP_YO_UPPER;
                1: return CP_YO_LOWER;
                2: return CP_SHORT_I_UPPER;
                default: return CP_SHORT_I_LOWER;
            endcase
        end
        return CP_UPPER_FIRST + 11'($urandom_range(0, 63));
    endfunction

    // Mostly well-formed text; the rest carries stray bytes, unsupported letters or a cut-off lead.
    task automatic build_random_string();
        int          len;
        int          pick;
        bit          wellformed;
        logic [10:0] cp;
        logic [7:0]  b;
        text_bytes.delete();
        wellformed = ($urandom_range(0, 99) < 80);
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                b = 8'($urandom_range(0, 127));
                text_bytes.push_back(b);
            end else if (wellformed || pick < 85) begin
                cp = random_letter(!wellformed);
                text_bytes.push_back({3'b110, cp[10:6]});
                text_bytes.push_back({2'b10, cp[5:0]});
            end else begin
                b = 8'($urandom_range(0, 255));
                text_bytes.push_back(b);
            end
        end
        if (!wellformed && $urandom_range(0, 2) == 0)
            text_bytes.push_back($urandom_range(0, 1) ? LEAD_D1 : LEAD_D0);
    endtask

    task automatic test_ascii_folding();
        text_bytes = '{8'h41, 8'h5A, 8'h7A, 8'h00, 8'h7F};
        send_string();
    endtask

    task automatic test_cyrillic_folding();
        // Yo and short i in both cases, then the first capital and the last small letter.
        text_bytes = '{8'hD0, 8'h81, 8'hD1, 8'h91, 8'hD0, 8'h99, 8'hD0, 8'hB9,
                       8'hD0, 8'h90, 8'hD1, 8'h8F};
        send_string();
    endtask

    task automatic test_unsupported_input();
        text_bytes = '{8'hFF};
        send_string();
        // A bad trail byte; the byte after it must produce no byte beat, only the end result.
        text_bytes = '{8'hD0, 8'h41, 8'h5A};
        send_string();
        text_bytes = '{8'hD1, 8'h90};
        send_string();
        text_bytes = '{8'hD0};
        send_string();
    endtask

    task automatic test_capacity_limits();
        set_capacity(16'h0000);
        text_bytes = '{8'h41};
        send_string();
        set_capacity(16'h0001);
        text_bytes = '{8'hD0, 8'h90};
        send_string();
        text_bytes = '{8'h41, 8'h42};
        send_string();
        set_capacity(16'hFFFF);
    endtask

    task automatic test_backpressure();
        logic [7:0] b;
        text_bytes.delete();
        for (int i = 0; i < 30; i++) begin
            b = 8'($urandom_range(0, 127));
            text_bytes.push_back(b);
        end
        hold_request = HoldCycles;
        send_string();
    endtask

    task automatic test_random_strings(input logic [15:0] cap, input int budget,
                                       input bit steady);
        int start;
        set_capacity(cap);
        no_idle = steady;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            build_random_string();
            send_string();
        end
        no_idle = 1'b0;
    endtask

    // Receiver: random stalls (none while no_idle is set), plus a long hold-off on request.
    initial begin
        int hold_left;
        hold_left     = 0;
        fold_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                fold_ch.ready = 1'b0;
                hold_left--;
            end else if (no_idle) begin
                fold_ch.ready = 1'b1;
            end else begin
                fold_ch.ready = ($urandom_range(0, 99) >= 23);
            end
        end
    end

    always @(posedge clk) begin
        result_t want;
        if (rst_n && fold_ch.valid && fold_ch.ready) begin
            beats_seen++;
            if (fold_ch.kind == KIND_END) begin
                if (fold_ch.status == ST_OK) ends_ok++;
                else if (fold_ch.status == ST_UNSUPPORTED) ends_unsup++;
                else ends_ovf++;
            end
            if (expected_folds.size() == 0) begin
                $error("unexpected beat: kind %0h out_byte %0h status %0h count %0h",
                       fold_ch.kind, fold_ch.out_byte, fold_ch.status,
                       fold_ch.written_count);
                error_count++;
            end else begin
                want = expected_folds.pop_front();
                if (fold_ch.kind !== want.kind) begin
                    $error("kind: expected %0h, got %0h", want.kind, fold_ch.kind);
                    error_count++;
                end
                if (fold_ch.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte,
                           fold_ch.out_byte);
                    error_count++;
                end
                if (fold_ch.status !== want.status) begin
                    $error("status: expected %0h, got %0h", want.status, fold_ch.status);
                    error_count++;
                end
                if (fold_ch.written_count !== want.written_count) begin
                    $error("written_count: expected %0d, got %0d", want.written_count,
                           fold_ch.written_count);
                    error_count++;
                end
                if (fold_ch.end_of_run !== want.end_of_run) begin
                    $error("end_of_run: expected %0h, got %0h", want.end_of_run,
                           fold_ch.end_of_run);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (text_ch.valid && text_ch.ready) || (fold_ch.valid && fold_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QuietLimit) begin
            $error("no beat accepted for %0d cycles", QuietLimit);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        rst_n             = 1'b0;
        text_ch.valid     = 1'b0;
        text_ch.in_byte   = 8'h00;
        text_ch.is_last   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.byte_limit = 16'h0000;
        model_state       = '0;
        model_cap         = CAP_RESET;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_ascii_folding();
        test_cyrillic_folding();
        test_unsupported_input();
        test_capacity_limits();
        test_backpressure();
        test_random_strings(16'hFFFF, 80, 1'b0);
        test_random_strings(16'($urandom_range(0, 24)), 60, 1'b0);
        test_random_strings(16'h0000, 30, 1'b0);
        test_random_strings(16'($urandom_range(4, 40)), 90, 1'b1);
        test_random_strings(16'($urandom_range(0, 65535)), 30, 1'b0);
        test_random_strings(16'hFFFF, 70, 1'b0);

        wait_drained();
        $display("Sent %0d text bytes, checked %0d result beats over %0d capacity writes.",
                 bytes_sent, beats_seen, cap_writes);
        $display("End results: %0d ok, %0d unsupported, %0d overflow.",
                 ends_ok, ends_unsup, ends_ovf);
        if (error_count == 0 && expected_folds.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/ucf_pkg.sv
design/ucf_ifs.sv
design/ucf_step.sv
design/utf8_cyrillic_case_folder_core.sv
tb/sv/utf8_cyrillic_case_folder_core_test.sv
